// File: rtl/mi4_pkg.sv
// shared types, constants and index functions for the 4x4 matrix inverse
package mi4_pkg;

  localparam int DIM         = 4;
  localparam int CELLS       = DIM * DIM;
  localparam int OUT_FRAC    = 16;
  localparam int QBITS       = 34;

  typedef enum logic [3:0] {
    S_LOAD,
    S_READ,
    S_MUL,
    S_ACC,
    S_DETRD,
    S_DETMUL,
    S_DIVRD,
    S_DIVGO,
    S_DIVWAIT,
    S_OUT
  } state_e;

  // column pick of each factor in the six terms of a 3x3 determinant
  function automatic logic [1:0] term_col(input logic [2:0] term, input logic [1:0] fac);
    logic [1:0] k;
    k = 2'd0;
    case (term)
      3'd0: k = fac;
      3'd1: k = (fac == 2'd0) ? 2'd1 : (fac == 2'd1) ? 2'd2 : 2'd0;
      3'd2: k = (fac == 2'd0) ? 2'd2 : (fac == 2'd1) ? 2'd0 : 2'd1;
      3'd3: k = (fac == 2'd0) ? 2'd2 : (fac == 2'd1) ? 2'd1 : 2'd0;
      3'd4: k = (fac == 2'd0) ? 2'd0 : (fac == 2'd1) ? 2'd2 : 2'd1;
      3'd5: k = (fac == 2'd0) ? 2'd1 : (fac == 2'd1) ? 2'd0 : 2'd2;
      default: k = 2'd0;
    endcase
    return k;
  endfunction

  // store address of one factor of the minor that drops row i and column j
  function automatic logic [3:0] elem_addr(input logic [1:0] i, input logic [1:0] j,
                                           input logic [2:0] term, input logic [1:0] fac);
    logic [1:0] k;
    logic [1:0] row;
    logic [1:0] col;
    k   = term_col(term, fac);
    row = (fac >= i) ? fac + 2'd1 : fac;
    col = (k >= j) ? k + 2'd1 : k;
    return {row, col};
  endfunction

endpackage

// File: rtl/matrix4_inverse_adjugate.sv
// 4x4 matrix inverse by cofactors and adjugate, one element in, one entry out per item
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------------
//  in      | in_valid_i / in_stall_o | element_value_i
//  out     | out_valid_o/ out_stall_i| inverse_value_o out_row_o out_col_o
//          |                         | singular_o last_entry_o
//
// loading accepts one element per cycle; after the sixteenth the cofactor pass runs
// each cofactor as 6 terms of 3 reads and multiplies through the element memory
// port, plus a determinant read and multiply-accumulate per row-0 cofactor
// each entry then takes a cofactor read, a divider start, the divide (skipped for a
// singular matrix) and an output state, which holds while the output is stalled
// in_stall_o is high from the sixteenth element until the last entry is taken
// reset clears the load count and the sequencer; the memories are not cleared
module matrix4_inverse_adjugate #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ELEMENT_WIDTH-1:0] element_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              inverse_value_o,
  output logic [1:0]                      out_row_o,
  output logic [1:0]                      out_col_o,
  output logic                            singular_o,
  output logic                            last_entry_o
);
  import mi4_pkg::*;

  localparam int E  = ELEMENT_WIDTH;
  localparam int CW = 3 * E + 2;
  localparam int PW = CW + E;
  localparam int DW = 4 * E + 2;
  localparam int NW = CW + FRACTION_BITS + OUT_FRAC;

  state_e state_q, state_d;

  logic [3:0] load_q, load_d;
  logic [3:0] cidx_q, cidx_d;
  logic [2:0] term_q, term_d;
  logic [1:0] fac_q, fac_d;
  logic [3:0] oidx_q, oidx_d;
  logic       ovalid_q, ovalid_d;

  logic signed [CW-1:0] prod_q, prod_d, acc_q, acc_d, cof_q, cof_d;
  logic signed [DW-1:0] det_q, det_d;
  logic signed [31:0]   oval_q, oval_d;
  logic [1:0]           orow_q, orow_d, ocol_q, ocol_d;
  logic                 osing_q, osing_d, olast_q, olast_d;

  logic signed [E-1:0]  m_mem [CELLS];
  logic signed [E-1:0]  m_rd_q;
  logic [3:0]           m_ra;
  logic signed [CW-1:0] c_mem [CELLS];
  logic signed [CW-1:0] c_rd_q;
  logic                 c_we;

  logic                 in_acc;
  logic signed [CW-1:0] mul_a, sum, cof_val;
  logic signed [PW-1:0] mul_p;
  logic                 sing;
  logic                 div_start, div_done, div_neg;
  logic [CW-1:0]        cmag;
  logic [DW-1:0]        dmag;
  logic [31:0]          div_q;

  assign in_stall_o = state_q != S_LOAD;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sing       = det_q == '0;

  // memories
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_mem[load_q] <= element_value_i;
    end
    m_rd_q <= m_mem[m_ra];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[{cidx_q[1:0], cidx_q[3:2]}] <= cof_val;
    end
    c_rd_q <= c_mem[oidx_q];
  end

  assign m_ra  = (state_q == S_DETRD) ? {2'd0, cidx_q[1:0]}
                                      : elem_addr(cidx_q[3:2], cidx_q[1:0], term_q, fac_q);
  assign mul_a = (state_q == S_DETMUL) ? cof_q : prod_q;
  assign mul_p = mul_a * m_rd_q;
  assign sum   = (term_q < 3'd3) ? acc_q + prod_q : acc_q - prod_q;
  assign cof_val = (cidx_q[2] ^ cidx_q[0]) ? -sum : sum;
  assign c_we  = state_q == S_ACC && term_q == 3'd5;

  assign cmag      = c_rd_q[CW-1] ? CW'(-c_rd_q) : CW'(c_rd_q);
  assign dmag      = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
  assign div_neg   = c_rd_q[CW-1] ^ det_q[DW-1];
  assign div_start = state_q == S_DIVGO && !sing;

  mi4_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .neg_i  (div_neg),
    .num_i  ({cmag, {(FRACTION_BITS + OUT_FRAC){1'b0}}}),
    .den_i  (dmag),
    .done_o (div_done),
    .quot_o (div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:    if (in_acc && load_q == 4'(CELLS - 1)) state_d = S_READ;
      S_READ:    state_d = S_MUL;
      S_MUL:     state_d = (fac_q == 2'd2) ? S_ACC : S_READ;
      S_ACC: begin
        if (term_q != 3'd5) state_d = S_READ;
        else if (cidx_q[3:2] == 2'd0) state_d = S_DETRD;
        else if (cidx_q == 4'(CELLS - 1)) state_d = S_DIVRD;
        else state_d = S_READ;
      end
      S_DETRD:   state_d = S_DETMUL;
      S_DETMUL:  state_d = S_READ;
      S_DIVRD:   state_d = S_DIVGO;
      S_DIVGO:   state_d = sing ? S_OUT : S_DIVWAIT;
      S_DIVWAIT: if (div_done) state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) state_d = (oidx_q == 4'(CELLS - 1)) ? S_LOAD : S_DIVRD;
      end
      default:   state_d = S_LOAD;
    endcase
  end

  // datapath and counters
  always_comb begin
    load_d   = load_q;
    cidx_d   = cidx_q;
    term_d   = term_q;
    fac_d    = fac_q;
    oidx_d   = oidx_q;
    ovalid_d = ovalid_q;
    prod_d   = prod_q;
    acc_d    = acc_q;
    cof_d    = cof_q;
    det_d    = det_q;
    oval_d   = oval_q;
    orow_d   = orow_q;
    ocol_d   = ocol_q;
    osing_d  = osing_q;
    olast_d  = olast_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          load_d = load_q + 4'd1;
          cidx_d = '0;
          term_d = '0;
          fac_d  = '0;
          acc_d  = '0;
          det_d  = '0;
          oidx_d = '0;
        end
      end
      S_MUL: begin
        prod_d = (fac_q == 2'd0) ? CW'(m_rd_q) : $signed(mul_p[CW-1:0]);
        fac_d  = (fac_q == 2'd2) ? 2'd0 : fac_q + 2'd1;
      end
      S_ACC: begin
        if (term_q == 3'd5) begin
          cof_d  = cof_val;
          acc_d  = '0;
          term_d = '0;
          if (cidx_q[3:2] != 2'd0) cidx_d = cidx_q + 4'd1;
        end else begin
          acc_d  = sum;
          term_d = term_q + 3'd1;
        end
      end
      S_DETMUL: begin
        det_d  = det_q + DW'(mul_p);
        cidx_d = cidx_q + 4'd1;
      end
      S_DIVGO: begin
        if (sing) begin
          oval_d   = '0;
          ovalid_d = 1'b1;
        end
        orow_d  = oidx_q[3:2];
        ocol_d  = oidx_q[1:0];
        osing_d = sing;
        olast_d = oidx_q == 4'(CELLS - 1);
      end
      S_DIVWAIT: begin
        if (div_done) begin
          oval_d   = div_q;
          ovalid_d = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          ovalid_d = 1'b0;
          oidx_d   = oidx_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      load_q   <= '0;
      cidx_q   <= '0;
      term_q   <= '0;
      fac_q    <= '0;
      oidx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      load_q   <= load_d;
      cidx_q   <= cidx_d;
      term_q   <= term_d;
      fac_q    <= fac_d;
      oidx_q   <= oidx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    cof_q   <= cof_d;
    det_q   <= det_d;
    oval_q  <= oval_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    osing_q <= osing_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = ovalid_q;
  assign inverse_value_o = oval_q;
  assign out_row_o       = orow_q;
  assign out_col_o       = ocol_q;
  assign singular_o      = osing_q;
  assign last_entry_o    = olast_q;

  a_no_out_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o) else $error("entry shown while loading");

  a_last_is_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_entry_o |-> out_row_o == 2'd3 && out_col_o == 2'd3)
    else $error("last entry not at row 3 column 3");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> inverse_value_o == '0)
    else $error("singular entry not zero");

  a_full_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && load_q == 4'(CELLS - 1) |=> in_stall_o && load_q == '0)
    else $error("sixteenth element did not start the cofactor pass");

endmodule

// File: rtl/mi4_div.sv
// iterative restoring divider: rounded, saturated signed Q16.16 quotient
module mi4_div #(
  parameter int NW = 43,
  parameter int DW = 66
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          neg_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [31:0]   quot_o
);
  import mi4_pkg::*;

  localparam int HW = NW - QBITS;
  localparam int RW = ((HW > DW) ? HW : DW) + 1;
  localparam int CNTW = $clog2(QBITS);

  logic            busy_q, fin_q, neg_q, sat_q;
  logic [CNTW-1:0] cnt_q;
  logic [RW-1:0]   rem_q, den_q;
  logic [QBITS-1:0] lo_q, q_q;

  logic [RW-1:0] hi_x, den_x, trial;
  logic          ge;
  logic          rnd;
  logic [QBITS:0] qr, lim, qs;

  assign hi_x  = {{(RW-HW){1'b0}}, num_i[NW-1:QBITS]};
  assign den_x = {{(RW-DW){1'b0}}, den_i};
  assign trial = {rem_q[RW-2:0], lo_q[QBITS-1]};
  assign ge    = trial >= den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= !(hi_x >= den_x);
        fin_q  <= hi_x >= den_x;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b1;
      end else begin
        fin_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi_x;
      den_q <= den_x;
      lo_q  <= num_i[QBITS-1:0];
      q_q   <= '0;
      neg_q <= neg_i;
      sat_q <= hi_x >= den_x;
      cnt_q <= CNTW'(QBITS - 1);
    end else if (busy_q) begin
      rem_q <= ge ? trial - den_q : trial;
      lo_q  <= {lo_q[QBITS-2:0], 1'b0};
      q_q   <= {q_q[QBITS-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // round half away from zero on the magnitude, then clamp
  assign rnd = {rem_q, 1'b0} >= {1'b0, den_q};
  assign qr  = {1'b0, q_q} + (QBITS+1)'(rnd);
  assign lim = neg_q ? (QBITS+1)'(32'h8000_0000) : (QBITS+1)'(32'h7FFF_FFFF);
  assign qs  = (sat_q || qr > lim) ? lim : qr;

  assign done_o = fin_q;
  assign quot_o = neg_q ? 32'd0 - qs[31:0] : qs[31:0];

endmodule
